@@ design/lfru_pkg.sv @@
// shared constants and codes for the lfru segment buffer replacement core
package lfru_pkg;

  localparam int LfruEntries    = 64;
  localparam int LfruTimeBits   = 32;
  localparam logic [31:0] PeriodReset = 32'd500;
  localparam logic [6:0]  LimitReset  = 7'd64;

  // request kinds
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_PERIOD = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;

  // configuration register indexes
  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [31:0] file;
    logic [31:0] seg;
  } key_t;

endpackage

@@ design/lfru_segment_buffer_replacement_core.sv @@
// top level of the lfru segment buffer replacement core
// A table of cached (file, segment) pairs kept oldest first in two memories (keys and
// access metadata), served by a small sequencer around one 32x32 multiplier and one
// bit-serial divider. One request is taken at a time; s_tready is high only while the
// core is idle. A read or query walks the table, reading and comparing each entry in
// turn. A new-period request rewrites the metadata at one entry per cycle. A write
// on a table at its entry limit scores every entry, each score waiting on the 64-step
// divider for the frequency term, then shifts the later entries down and searches
// for a duplicate; a write with room left costs as a search.
// The result is held in an output register, and a new request may be taken while
// it waits.
module lfru_segment_buffer_replacement_core
  import lfru_pkg::*;
#(
  parameter int ENTRIES   = LfruEntries,
  parameter int TIME_BITS = LfruTimeBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // file_id, seg_id, now
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // status, present, evicted, evicted_file, evicted_seg,
                                  // added, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int TB = TIME_BITS;
  localparam int SW = ((TB + 32 > 64) ? TB + 32 : 64) + 1;

  typedef struct packed {
    logic [31:0]   count;
    logic [TB-1:0] last;
  } meta_t;

  typedef enum logic [4:0] {
    S_IDLE, S_W_CHK, S_W_PREP, S_W_EE, S_W_EE2,
    S_SC_RD, S_SC_R, S_SC_MLO, S_SC_MHI, S_SC_ADD, S_SC_DIV, S_SC_ADD2, S_SC_CMP,
    S_VIC_RD, S_VIC_GET, S_SH_RD, S_SH_WR, S_SH_END,
    S_FIND_RD, S_FIND_CMP, S_PER, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [31:0] period_length;
  logic [6:0]  block_limit;

  // request registers
  logic [1:0]    op_r;
  key_t          key_r;
  logic [TB-1:0] now_r;

  // table state
  logic [TB-1:0] period_start;
  logic [CW-1:0] total;
  logic [CW-1:0] idx;

  key_t  key_mem  [ENTRIES];
  meta_t meta_mem [ENTRIES];
  key_t  key_q;
  meta_t meta_q;

  // scoring datapath
  logic [31:0]   e_r;
  logic [31:0]   a_r;
  logic [63:0]   ee;
  logic [TB-1:0] r_r;
  logic [63:0]   mprod;
  logic [SW-1:0] acc;
  logic [SW-1:0] best;
  logic [CW-1:0] victim;
  logic [31:0]   dvs;
  logic [31:0]   rem;
  logic [63:0]   quot;
  logic [5:0]    dcnt;

  // result fields
  logic [1:0]  res_status;
  logic        res_present;
  logic        res_evicted;
  key_t        res_ev;
  logic        res_added;

  // write ports
  logic          key_we;
  logic [IW-1:0] key_wa;
  key_t          key_wd;
  logic          meta_we;
  logic [IW-1:0] meta_wa;
  meta_t         meta_wd;

  // derived values
  logic [TB+31:0] now_wide;
  logic [TB-1:0]  now_ext;
  logic [TB-1:0]  ediff;
  logic [31:0]    p_eff;
  logic [TB+31:0] ediff_w;
  logic [TB+31:0] p_w;
  logic [31:0]    e_clamp;
  logic [LW-1:0]  lim;
  logic [LW-1:0]  total_w;
  logic [TB+63:0] r_x;
  logic [31:0]    mul_x;
  logic [31:0]    mul_y;
  logic [32:0]    rem_sh;
  logic [32:0]    rem_sub;
  logic [95:0]    hi_shift;
  logic [31:0]    cnt_inc;
  logic [CW-1:0]  idx_prev;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // input time and period arithmetic
  assign now_wide = {{TB{1'b0}}, s_tdata[95:64]};
  assign now_ext  = now_wide[TB-1:0];
  assign ediff    = now_r - period_start;
  assign p_eff    = (period_length == 32'd0) ? 32'd1 : period_length;
  assign ediff_w  = {32'd0, ediff};
  assign p_w      = {{TB{1'b0}}, p_eff};
  assign e_clamp  = (ediff_w > p_w) ? p_eff : ediff_w[31:0];

  // effective entry limit
  always_comb begin
    total_w = LW'(total);
    if (block_limit == 7'd0) begin
      lim = LW'(1);
    end else if (LW'(block_limit) > LW'(ENTRIES)) begin
      lim = LW'(ENTRIES);
    end else begin
      lim = LW'(block_limit);
    end
  end

  // recency split into 32-bit halves
  assign r_x = {64'd0, r_r};

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_W_EE: begin
        mul_x = e_r;
        mul_y = e_r;
      end
      S_SC_MLO: begin
        mul_x = a_r;
        mul_y = r_x[31:0];
      end
      default: begin
        mul_x = a_r;
        mul_y = r_x[63:32];
      end
    endcase
  end

  // one restoring divider step
  assign rem_sh  = {rem, quot[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign hi_shift = {mprod, 32'd0};
  assign cnt_inc  = (meta_q.count == 32'hFFFF_FFFF) ? meta_q.count : meta_q.count + 32'd1;
  assign idx_prev = idx - CW'(1);

  // memory write selection
  always_comb begin
    key_we  = 1'b0;
    key_wa  = idx[IW-1:0];
    key_wd  = key_r;
    meta_we = 1'b0;
    meta_wa = idx[IW-1:0];
    meta_wd.count = 32'd1;
    meta_wd.last  = now_r;
    case (state)
      S_SH_WR: begin
        key_we  = 1'b1;
        key_wa  = idx_prev[IW-1:0];
        key_wd  = key_q;
        meta_we = 1'b1;
        meta_wa = idx_prev[IW-1:0];
        meta_wd = meta_q;
      end
      S_FIND_RD: begin
        if (idx == total && op_r == OP_WRITE && total < CW'(ENTRIES)) begin
          key_we  = 1'b1;
          key_wa  = total[IW-1:0];
          meta_we = 1'b1;
          meta_wa = total[IW-1:0];
          meta_wd.last = period_start;
        end
      end
      S_FIND_CMP: begin
        if (key_q == key_r && op_r == OP_READ) begin
          meta_we = 1'b1;
          meta_wd.count = cnt_inc;
        end
      end
      S_PER: begin
        meta_we = (idx != total);
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    key_q  <= key_mem[idx[IW-1:0]];
    meta_q <= meta_mem[idx[IW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_length <= PeriodReset;
      block_limit   <= LimitReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PERIOD: period_length <= cfg_data;
        CFG_LIMIT:  block_limit   <= cfg_data[6:0];
        default:    period_length <= period_length;
      endcase
    end
  end

  // sequencer, datapath and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= '0;
      period_start <= '0;
      idx          <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // the done state drives m_tvalid itself when it hands over a result
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r        <= s_tuser;
            key_r.file  <= s_tdata[31:0];
            key_r.seg   <= s_tdata[63:32];
            now_r       <= now_ext;
            res_status  <= ST_OK;
            res_present <= 1'b0;
            res_evicted <= 1'b0;
            res_ev      <= '0;
            res_added   <= 1'b0;
            idx         <= '0;
            case (s_tuser)
              OP_WRITE: state <= S_W_CHK;
              OP_PERIOD: begin
                period_start <= now_ext;
                state        <= S_PER;
              end
              default: state <= S_FIND_RD;
            endcase
          end
        end
        // decide whether the table must give up an entry
        S_W_CHK: begin
          state <= (total_w >= lim) ? S_W_PREP : S_FIND_RD;
        end
        S_W_PREP: begin
          e_r   <= e_clamp;
          a_r   <= p_eff - e_clamp;
          state <= S_W_EE;
        end
        S_W_EE: begin
          mprod <= mul_x * mul_y;
          state <= S_W_EE2;
        end
        S_W_EE2: begin
          ee     <= mprod;
          best   <= '0;
          victim <= '0;
          state  <= S_SC_RD;
        end
        // score loop over all entries
        S_SC_RD: begin
          if (idx == total) begin
            idx   <= victim;
            state <= S_VIC_RD;
          end else begin
            state <= S_SC_R;
          end
        end
        S_SC_R: begin
          r_r   <= now_r - meta_q.last;
          dvs   <= (meta_q.count == 32'd0) ? 32'd1 : meta_q.count;
          rem   <= '0;
          quot  <= ee;
          dcnt  <= '0;
          state <= S_SC_MLO;
        end
        S_SC_MLO: begin
          mprod <= mul_x * mul_y;
          state <= S_SC_MHI;
        end
        S_SC_MHI: begin
          acc   <= SW'(mprod);
          mprod <= mul_x * mul_y;
          state <= S_SC_ADD;
        end
        S_SC_ADD: begin
          acc   <= acc + SW'(hi_shift);
          state <= S_SC_DIV;
        end
        S_SC_DIV: begin
          if (!rem_sub[32]) begin
            rem  <= rem_sub[31:0];
            quot <= {quot[62:0], 1'b1};
          end else begin
            rem  <= rem_sh[31:0];
            quot <= {quot[62:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            state <= S_SC_ADD2;
          end
        end
        S_SC_ADD2: begin
          acc   <= acc + SW'(quot);
          state <= S_SC_CMP;
        end
        S_SC_CMP: begin
          if (acc > best) begin
            best   <= acc;
            victim <= idx;
          end
          idx   <= idx + CW'(1);
          state <= S_SC_RD;
        end
        // pick up the victim and close the gap
        S_VIC_RD: begin
          state <= S_VIC_GET;
        end
        S_VIC_GET: begin
          res_evicted <= 1'b1;
          res_ev      <= key_q;
          idx         <= idx + CW'(1);
          state       <= S_SH_RD;
        end
        S_SH_RD: begin
          state <= (idx >= total) ? S_SH_END : S_SH_WR;
        end
        S_SH_WR: begin
          idx   <= idx + CW'(1);
          state <= S_SH_RD;
        end
        S_SH_END: begin
          total <= total - CW'(1);
          idx   <= '0;
          state <= S_FIND_RD;
        end
        // linear search for the requested pair
        S_FIND_RD: begin
          if (idx == total) begin
            case (op_r)
              OP_WRITE: begin
                if (total < CW'(ENTRIES)) begin
                  total     <= total + CW'(1);
                  res_added <= 1'b1;
                end
              end
              OP_READ:  res_status <= ST_NOT_FOUND;
              default:  res_present <= 1'b0;
            endcase
            state <= S_DONE;
          end else begin
            state <= S_FIND_CMP;
          end
        end
        S_FIND_CMP: begin
          if (key_q == key_r) begin
            if (op_r == OP_WRITE) begin
              res_status <= ST_DUPLICATE;
            end else begin
              res_present <= 1'b1;
            end
            state <= S_DONE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FIND_RD;
          end
        end
        // new period sweep
        S_PER: begin
          if (idx == total) begin
            state <= S_DONE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'd0, res_added, res_ev.seg, res_ev.file,
                         res_evicted, res_present, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for the lfru segment buffer replacement core
module tb;
  import lfru_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic        evicted;
    logic [31:0] ev_file;
    logic [31:0] ev_seg;
    logic        added;
  } res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] file;
    logic [31:0] seg;
    logic [31:0] now;
    logic        known;
    res_t        res;
  } row_t;

  localparam int DirRows   = 12;
  localparam int PoolSize  = 80;
  localparam int NumPhases = 9;
  localparam int DogLimit  = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_QUERY;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_PERIOD;
  logic [31:0] cfg_data = '0;

  lfru_segment_buffer_replacement_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the table and its registers
  logic [31:0] tab_file [LfruEntries];
  logic [31:0] tab_seg  [LfruEntries];
  logic [31:0] tab_cnt  [LfruEntries];
  logic [31:0] tab_last [LfruEntries];
  int          tab_total;
  logic [31:0] period_begin;
  logic [31:0] period_len;
  logic [6:0]  limit_reg;

  res_t        pending_results[$];
  int          mismatches;
  bit          quiet;
  logic [31:0] pool_file [PoolSize];
  logic [31:0] pool_seg  [PoolSize];
  logic [31:0] clock_ticks;

  function automatic int find_key(logic [31:0] f, logic [31:0] s);
    for (int i = 0; i < tab_total; i++)
      if (tab_file[i] == f && tab_seg[i] == s) return i;
    return -1;
  endfunction

  // apply one request to the shadow table and work out its result
  function automatic res_t apply_request(logic [1:0] op, logic [31:0] f, logic [31:0] s,
                                         logic [31:0] n);
    res_t        r;
    int          lim;
    int          victim;
    int          hit;
    logic [63:0] p, e, cnt;
    logic [31:0] age;
    logic [127:0] score, best;
    r = '0;
    case (op)
      OP_WRITE: begin
        lim = (limit_reg == 0) ? 1 : (limit_reg > LfruEntries ? LfruEntries : limit_reg);
        if (tab_total >= lim && tab_total > 0) begin
          p = (period_len == 0) ? 64'd1 : 64'(period_len);
          e = 64'(n - period_begin);
          if (e > p) e = p;
          best = '0;
          victim = 0;
          for (int i = 0; i < tab_total; i++) begin
            age = n - tab_last[i];
            cnt = (tab_cnt[i] == 0) ? 64'd1 : 64'(tab_cnt[i]);
            score = 128'(p - e) * 128'(age) + 128'((e * e) / cnt);
            if (score > best) begin
              best = score;
              victim = i;
            end
          end
          r.evicted = 1'b1;
          r.ev_file = tab_file[victim];
          r.ev_seg  = tab_seg[victim];
          for (int i = victim; i + 1 < tab_total; i++) begin
            tab_file[i] = tab_file[i+1];
            tab_seg[i]  = tab_seg[i+1];
            tab_cnt[i]  = tab_cnt[i+1];
            tab_last[i] = tab_last[i+1];
          end
          tab_total--;
        end
        if (find_key(f, s) >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (tab_total < LfruEntries) begin
          tab_file[tab_total] = f;
          tab_seg[tab_total]  = s;
          tab_cnt[tab_total]  = 32'd1;
          tab_last[tab_total] = period_begin;
          tab_total++;
          r.added = 1'b1;
        end
      end
      OP_READ: begin
        hit = find_key(f, s);
        if (hit >= 0) begin
          if (tab_cnt[hit] != 32'hFFFF_FFFF) tab_cnt[hit]++;
          tab_last[hit] = n;
          r.present = 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_QUERY: r.present = (find_key(f, s) >= 0);
      default: begin
        period_begin = n;
        for (int i = 0; i < tab_total; i++) begin
          tab_cnt[i]  = 32'd1;
          tab_last[i] = n;
        end
      end
    endcase
    return r;
  endfunction

  // drive one request; typed result is used where the row gives one
  task automatic send_request(logic [1:0] op, logic [31:0] f, logic [31:0] s,
                              logic [31:0] n, logic known, res_t typed);
    res_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {n, s, f};
    do @(posedge clk); while (!s_tready);
    r = apply_request(op, f, s, n);
    if (known) r = typed;
    pending_results = {pending_results, r};
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PERIOD) period_len = val;
    else limit_reg = val[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver stalls
  always @(negedge clk)
    m_tready <= quiet || ($urandom_range(0, 99) >= 16);

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[1:0], m_tdata[2], m_tdata[3], m_tdata[35:4], m_tdata[67:36],
             m_tdata[68]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.present !== want.present ||
            got.evicted !== want.evicted || got.ev_file !== want.ev_file ||
            got.ev_seg !== want.ev_seg || got.added !== want.added) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d pr=%0d ev=%0d %h/%h add=%0d, got st=%0d pr=%0d ev=%0d %h/%h add=%0d",
                     want.status, want.present, want.evicted, want.ev_file, want.ev_seg,
                     want.added, got.status, got.present, got.evicted, got.ev_file,
                     got.ev_seg, got.added);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= DogLimit) begin
      $display("lfru_segment_buffer_replacement_core test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  row_t rows [DirRows];
  logic [31:0] phase_period [NumPhases] = '{32'd500, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd37,
                                            32'd1000, 32'd20, 32'd300, 32'd7};
  logic [6:0]  phase_limit [NumPhases] = '{7'd4, 7'd1, 7'd2, 7'd8, 7'd3, 7'd64, 7'd127,
                                           7'd0, 7'd16};
  int          phase_items [NumPhases] = '{110, 60, 80, 100, 80, 110, 30, 60, 100};
  int          phase_pool  [NumPhases] = '{12, 6, 8, 20, 10, 80, 80, 6, 30};

  initial begin
    logic [1:0]  op;
    logic [31:0] f, s, n;
    int          k, pick;
    mismatches   = 0;
    quiet        = 1'b0;
    tab_total    = 0;
    period_begin = '0;
    period_len   = PeriodReset;
    limit_reg    = LimitReset;
    clock_ticks  = 32'd50;
    for (int i = 0; i < PoolSize; i++) begin
      pool_file[i] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 5);
      pool_seg[i]  = $urandom();
    end
    pool_file[0] = 32'h0;          pool_seg[0] = 32'h0;
    pool_file[1] = 32'hFFFF_FFFF;  pool_seg[1] = 32'hFFFF_FFFF;

    // directed rows at reset settings
    rows = '{
      '{OP_QUERY,  32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_READ,   32'h0, 32'h0, 32'h5, 1'b1, '{ST_NOT_FOUND, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_WRITE,  32'h0, 32'h0, 32'h9, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'h0, 32'h0, 1'b1}},
      '{OP_WRITE,  32'h0, 32'h0, 32'hA, 1'b1, '{ST_DUPLICATE, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK, 1'b0, 1'b0, 32'h0, 32'h0, 1'b1}},
      '{OP_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h10, 1'b1,
        '{ST_OK, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_QUERY,  32'h0, 32'h0, 32'h11, 1'b1, '{ST_OK, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_QUERY,  32'hFFFF_FFFF, 32'h0, 32'h12, 1'b1,
        '{ST_OK, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_PERIOD, 32'h0, 32'h0, 32'd40, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0}},
      '{OP_WRITE,  32'h0, 32'hFFFF_FFFF, 32'd45, 1'b0, '0},
      '{OP_READ,   32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0, '0},
      '{OP_WRITE,  32'hFFFF_FFFF, 32'h0, 32'd3, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++)
      send_request(rows[i].op, rows[i].file, rows[i].seg, rows[i].now, rows[i].known,
                   rows[i].res);
    drain();

    // random phases, each at its own settings, written while idle
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(CFG_PERIOD, phase_period[ph]);
      write_reg(CFG_LIMIT, {$urandom_range(0, 1) ? $urandom() : 32'h0} & 32'hFFFF_FF80
                           | 32'(phase_limit[ph]));
      quiet = (ph == 3);
      for (int it = 0; it < phase_items[ph]; it++) begin
        k = $urandom_range(0, 99);
        op = (k < 40) ? OP_WRITE : (k < 70) ? OP_READ : (k < 93) ? OP_QUERY : OP_PERIOD;
        if ($urandom_range(0, 9) == 0) begin
          f = $urandom();
          s = $urandom();
        end else begin
          pick = $urandom_range(0, phase_pool[ph] - 1);
          f = pool_file[pick];
          s = pool_seg[pick];
        end
        clock_ticks = clock_ticks + $urandom_range(0, 2 * phase_period[ph] % 700 + 20);
        n = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ticks;
        send_request(op, f, s, n, 1'b0, '0);
      end
      drain();
    end
    quiet = 1'b0;

    if (mismatches == 0 && pending_results.size() == 0)
      $display("lfru_segment_buffer_replacement_core test passed");
    else
      $display("lfru_segment_buffer_replacement_core test failed");
    $finish;
  end

endmodule
